### rtl/glt_pkg.sv
// ----------------------------------------------------------------------------
// glt_pkg: shared definitions of the greedy longest match tokenizer
// Field widths, register indexes, parameter defaults and the sequencer states.
// ----------------------------------------------------------------------------
package glt_pkg;

  // Defaults for the top level parameters.
  localparam int SEQ_DEPTH_DEF       = 64;
  localparam int LEX_ENTRIES_DEF     = 8;
  localparam int MAX_WORD_LEN_DEF    = 10;
  localparam int PHONEME_BITS_DEF    = 6;

  // Fixed field widths of the beats.
  localparam int TOKEN_W    = 32;
  localparam int LEN_W      = 4;
  localparam int CODES_W    = 60;
  localparam int PHON_IN_W  = 6;
  localparam int IDX_W      = 3;
  localparam int MAXTOK_W   = 7;
  localparam int LSIZE_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Most results one sequence can produce.
  localparam int RESULT_CAP = 64;

  localparam logic [MAXTOK_W-1:0] MAXTOK_RESET = 7'd20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEXICON_SIZE = 2'd1;

  // Input opcodes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PHONEME = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_RD,
    ST_CMP,
    ST_ADV,
    ST_DONE
  } state_e;

endpackage

### rtl/glt_ram.sv
// ----------------------------------------------------------------------------
// glt_ram: generic simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module glt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/greedy_longest_match_tokenizer.sv
// ----------------------------------------------------------------------------
// greedy_longest_match_tokenizer: phoneme sequence to lexicon tokens
// Greedy longest match of a buffered phoneme sequence against a small lexicon.
// ----------------------------------------------------------------------------
// Load and phoneme beats without last are taken while the sequencer is idle
// and may follow back to back. After the beat with last, each buffer position
// passes POS, then RD and CMP per phoneme compared (at most MAX_WORD_LEN), then
// ADV, with an extra RD when a candidate word runs past the end of the buffer.
// The final result is registered in DONE; results cannot be stalled. Reset
// clears the sequencer, fill count, flags and configuration registers only.
module greedy_longest_match_tokenizer #(
  parameter int SEQ_DEPTH       = glt_pkg::SEQ_DEPTH_DEF,
  parameter int LEXICON_ENTRIES = glt_pkg::LEX_ENTRIES_DEF,
  parameter int MAX_WORD_LEN    = glt_pkg::MAX_WORD_LEN_DEF,
  parameter int PHONEME_BITS    = glt_pkg::PHONEME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command channel.
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            opcode_i,
  input  logic [glt_pkg::IDX_W-1:0]       entry_index_i,
  input  logic [glt_pkg::LEN_W-1:0]       entry_length_i,
  input  logic [glt_pkg::TOKEN_W-1:0]     entry_token_i,
  input  logic [glt_pkg::CODES_W-1:0]     entry_phonemes_i,
  input  logic [glt_pkg::PHON_IN_W-1:0]   phoneme_i,
  input  logic                            last_i,
  // Result channel.
  output logic                            valid_o,
  output logic [glt_pkg::TOKEN_W-1:0]     token_o,
  output logic                            has_token_o,
  output logic                            last_token_o,
  output logic                            overflow_o,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [glt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [glt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import glt_pkg::*;

  // Fill count and scan position must hold SEQ_DEPTH itself.
  localparam int CW        = $clog2(SEQ_DEPTH + 1);
  localparam int AW        = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int WORD_BITS = MAX_WORD_LEN * PHONEME_BITS;
  // Codes past the stored word read as zero, so pad with a zero word.
  localparam int PAD_W     = CODES_W + WORD_BITS;

  localparam logic [LEN_W-1:0]    MAX_LEN  = LEN_W'(MAX_WORD_LEN);
  localparam logic [LEN_W-1:0]    LAST_STEP = LEN_W'(MAX_WORD_LEN - 1);
  localparam logic [MAXTOK_W-1:0] CAP      = MAXTOK_W'(RESULT_CAP);
  localparam logic [CW-1:0]       DEPTH_C  = CW'(SEQ_DEPTH);

  state_e state_q, state_d;

  // Configuration registers.
  logic [MAXTOK_W-1:0] max_tokens_q;
  logic [LSIZE_W-1:0]  lexicon_size_q;

  // Lexicon lanes, one per entry, each read at its own compare lane.
  logic [LEN_W-1:0]   lex_len_q   [LEXICON_ENTRIES];
  logic [TOKEN_W-1:0] lex_tok_q   [LEXICON_ENTRIES];
  logic [CODES_W-1:0] lex_codes_q [LEXICON_ENTRIES];

  // Sequence buffer bookkeeping.
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;

  // Scan state.
  logic [CW-1:0]              pos_q, pos_d;
  logic [LEN_W-1:0]           step_q, step_d;
  logic [LEXICON_ENTRIES-1:0] alive_q, alive_d;
  logic                       found_q, found_d;
  logic [LEN_W-1:0]           best_len_q, best_len_d;
  logic [TOKEN_W-1:0]         best_tok_q, best_tok_d;
  logic [MAXTOK_W-1:0]        emitted_q, emitted_d;

  // One held-back token, so that the final one can carry last_token.
  logic               pend_valid_q, pend_valid_d;
  logic [TOKEN_W-1:0] pend_tok_q, pend_tok_d;

  // Result register.
  logic               valid_q, valid_d;
  logic [TOKEN_W-1:0] token_q, token_d;
  logic               has_q, has_d;
  logic               lastt_q, lastt_d;
  logic               ovfo_q, ovfo_d;

  logic accept, load_acc, ph_acc, room;
  logic [PHONEME_BITS+PHON_IN_W-1:0] ph_wide;
  logic [PHONEME_BITS-1:0]           ph_code;
  logic [PHONEME_BITS-1:0]           rdata;
  logic [CW:0]                       rd_sum;
  logic                              in_range;
  logic                              ram_re;
  logic [MAXTOK_W-1:0]               limit;

  logic [LEXICON_ENTRIES-1:0] alive_init, alive_upd, complete, more;
  logic                       any_complete;
  logic [TOKEN_W-1:0]         sel_tok;
  logic [LEN_W-1:0]           step_inc;

  // A beat is taken only while the sequencer rests.
  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign load_acc = accept && (opcode_i == OP_LOAD);
  assign ph_acc   = accept && (opcode_i == OP_PHONEME);
  assign room     = (count_q < DEPTH_C);

  // Only the low PHONEME_BITS of the phoneme field are kept.
  assign ph_wide  = {{PHONEME_BITS{1'b0}}, phoneme_i};
  assign ph_code  = ph_wide[PHONEME_BITS-1:0];

  // Buffer address of the phoneme under comparison.
  assign rd_sum   = {1'b0, pos_q} + (CW + 1)'(step_q);
  assign in_range = (rd_sum < {1'b0, count_q});
  assign ram_re   = (state_q == ST_RD) && in_range;

  assign limit    = (max_tokens_q > CAP) ? CAP : max_tokens_q;
  assign step_inc = step_q + LEN_W'(1);

  glt_ram #(
    .WIDTH (PHONEME_BITS),
    .DEPTH (SEQ_DEPTH),
    .AW    (AW)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (ph_acc && room),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ph_code),
    .re_i    (ram_re),
    .raddr_i (rd_sum[AW-1:0]),
    .rdata_o (rdata)
  );

  // Compare lanes. Every entry in use checks its code at the current step
  // against the buffer phoneme; an entry stays alive while all codes so far
  // have matched. It completes at the step equal to its length minus one.
  always_comb begin
    logic [PAD_W-1:0]        padded;
    logic [PHONEME_BITS-1:0] code;
    logic                    longer;
    alive_init   = '0;
    alive_upd    = '0;
    complete     = '0;
    more         = '0;
    any_complete = 1'b0;
    sel_tok      = '0;
    for (int e = LEXICON_ENTRIES - 1; e >= 0; e--) begin
      padded = {{WORD_BITS{1'b0}}, lex_codes_q[e]};
      code   = padded[int'(step_q) * PHONEME_BITS +: PHONEME_BITS];
      longer = (lex_len_q[e] > step_q);
      alive_init[e] = (int'(lexicon_size_q) > e) && (lex_len_q[e] != '0) &&
                      (lex_len_q[e] <= MAX_LEN);
      alive_upd[e]  = alive_q[e] && !(longer && (code != rdata));
      complete[e]   = alive_upd[e] && (lex_len_q[e] == step_inc);
      more[e]       = alive_upd[e] && (lex_len_q[e] > step_inc);
      // Walking down leaves the lowest completed index selected.
      if (complete[e]) begin
        any_complete = 1'b1;
        sel_tok      = lex_tok_q[e];
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (ph_acc && last_i) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        if ((pos_q < count_q) && (emitted_q < limit)) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RD: begin
        // Past the end of the buffer no longer word can complete.
        state_d = in_range ? ST_CMP : ST_ADV;
      end
      ST_CMP: begin
        if ((step_q == LAST_STEP) || !(|more)) begin
          state_d = ST_ADV;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_ADV:  state_d = ST_POS;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer datapath.
  always_comb begin
    count_d      = count_q;
    ovf_d        = ovf_q;
    pos_d        = pos_q;
    step_d       = step_q;
    alive_d      = alive_q;
    found_d      = found_q;
    best_len_d   = best_len_q;
    best_tok_d   = best_tok_q;
    emitted_d    = emitted_q;
    pend_valid_d = pend_valid_q;
    pend_tok_d   = pend_tok_q;
    valid_d      = 1'b0;
    token_d      = token_q;
    has_d        = has_q;
    lastt_d      = lastt_q;
    ovfo_d       = ovfo_q;
    case (state_q)
      ST_IDLE: begin
        if (ph_acc) begin
          if (room) begin
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            pos_d        = '0;
            emitted_d    = '0;
            pend_valid_d = 1'b0;
          end
        end
      end
      ST_POS: begin
        alive_d = alive_init;
        step_d  = '0;
        found_d = 1'b0;
      end
      ST_RD: begin
      end
      ST_CMP: begin
        alive_d = alive_upd;
        step_d  = step_inc;
        // A later completion is a longer word and replaces the earlier one.
        if (any_complete) begin
          found_d    = 1'b1;
          best_len_d = step_inc;
          best_tok_d = sel_tok;
        end
      end
      ST_ADV: begin
        if (found_q) begin
          // The held token is known not to be the final one: send it.
          if (pend_valid_q) begin
            valid_d = 1'b1;
            token_d = pend_tok_q;
            has_d   = 1'b1;
            lastt_d = 1'b0;
            ovfo_d  = ovf_q;
          end
          pend_valid_d = 1'b1;
          pend_tok_d   = best_tok_q;
          emitted_d    = emitted_q + MAXTOK_W'(1);
          pos_d        = pos_q + CW'(best_len_q);
        end else begin
          pos_d = pos_q + CW'(1);
        end
      end
      ST_DONE: begin
        // Final beat: the held token, or an empty result if none was found.
        valid_d      = 1'b1;
        token_d      = pend_valid_q ? pend_tok_q : '0;
        has_d        = pend_valid_q;
        lastt_d      = 1'b1;
        ovfo_d       = ovf_q;
        count_d      = '0;
        ovf_d        = 1'b0;
        pend_valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      ovf_q          <= 1'b0;
      pend_valid_q   <= 1'b0;
      valid_q        <= 1'b0;
      max_tokens_q   <= MAXTOK_RESET;
      lexicon_size_q <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      valid_q      <= valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_TOKENS:   max_tokens_q   <= cfg_data_i[MAXTOK_W-1:0];
          CFG_LEXICON_SIZE: lexicon_size_q <= cfg_data_i[LSIZE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    step_q     <= step_d;
    alive_q    <= alive_d;
    found_q    <= found_d;
    best_len_q <= best_len_d;
    best_tok_q <= best_tok_d;
    emitted_q  <= emitted_d;
    pend_tok_q <= pend_tok_d;
    token_q    <= token_d;
    has_q      <= has_d;
    lastt_q    <= lastt_d;
    ovfo_q     <= ovfo_d;
  end

  // Lexicon load. A slot beyond the lexicon is ignored.
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < LEXICON_ENTRIES; e++) begin
      if (load_acc && (int'(entry_index_i) == e)) begin
        lex_len_q[e]   <= entry_length_i;
        lex_tok_q[e]   <= entry_token_i;
        lex_codes_q[e] <= entry_phonemes_i;
      end
    end
  end

  assign valid_o      = valid_q;
  assign token_o      = token_q;
  assign has_token_o  = has_q;
  assign last_token_o = lastt_q;
  assign overflow_o   = ovfo_q;

endmodule
